### rtl/mipa_pkg.sv
`timescale 1ns / 1ps

package mipa_pkg;

   localparam int MAX_WIDTH = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_IMAGES = 10;

   localparam int COMP_WIDTH = 8;
   localparam int SUM_WIDTH = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int COUNT_REG_WIDTH = 4;
   localparam int DIM_REG_WIDTH = 9;

   localparam logic [COUNT_REG_WIDTH-1:0] IMAGE_COUNT_RESET = 4'd2;
   localparam logic [DIM_REG_WIDTH-1:0] FRAME_WIDTH_RESET = 9'd256;
   localparam logic [DIM_REG_WIDTH-1:0] FRAME_HEIGHT_RESET = 9'd256;

   typedef enum logic [1:0] {
      REG_IMAGE_COUNT = 2'd0,
      REG_FRAME_WIDTH = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [COMP_WIDTH-1:0] red_in;
      logic [COMP_WIDTH-1:0] green_in;
      logic [COMP_WIDTH-1:0] blue_in;
   } req_pixel_type;

   typedef struct packed {
      logic [COMP_WIDTH-1:0] red_avg;
      logic [COMP_WIDTH-1:0] green_avg;
      logic [COMP_WIDTH-1:0] blue_avg;
      logic frame_done;
   } rsp_pixel_type;

   typedef struct packed {
      logic first;
      logic last;
      logic frame_done;
   } job_flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV
   } back_state_type;

endpackage

### rtl/mipa_ram.sv
`timescale 1ns / 1ps

module mipa_ram #(
   parameter int Width = 36,
   parameter int Depth = 65536,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mipa_fifo.sv
`timescale 1ns / 1ps

module mipa_fifo #(
   parameter int Width = 32,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   input  logic             pop,
   output logic [Width-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = entry_ff[rd_ptr_ff];
   assign full = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);

endmodule

### rtl/mipa_front.sv
`timescale 1ns / 1ps

module mipa_front #(
   parameter int MaxWidth = 256,
   parameter int MaxHeight = 256,
   parameter int MaxImages = 10,
   localparam int ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1,
   localparam int RowW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1,
   localparam int AddrW = (MaxWidth * MaxHeight > 1) ? $clog2(MaxWidth * MaxHeight) : 1,
   localparam int CntW = $clog2(MaxImages + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  logic [ColW-1:0]         col_last,
   input  logic [RowW-1:0]         row_last,
   input  logic [CntW-1:0]         count,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mipa_pkg::req_pixel_type req_data,
   input  logic                    fifo_full,
   output logic                    push,
   output logic [AddrW-1:0]        push_addr,
   output mipa_pkg::job_flags_type push_flags,
   output mipa_pkg::req_pixel_type push_pixel
);

   import mipa_pkg::*;

   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [AddrW-1:0] pos_ff, pos_in;
   logic [CntW-1:0]  img_ff, img_in;
   logic             end_col, end_row, last_img;

   assign end_col = (col_ff == col_last);
   assign end_row = (row_ff == row_last);
   assign last_img = (img_ff == count - CntW'(1));

   assign req_stall = fifo_full;
   assign push = req_valid && !fifo_full;
   assign push_addr = pos_ff;
   assign push_pixel = req_data;
   assign push_flags.first = (img_ff == '0);
   assign push_flags.last = last_img;
   assign push_flags.frame_done = last_img && end_col && end_row;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      pos_in = pos_ff;
      img_in = img_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
         pos_in = '0;
         img_in = '0;
      end else if (push) begin
         if (end_col) begin
            col_in = '0;
            if (end_row) begin
               row_in = '0;
               pos_in = '0;
               img_in = last_img ? '0 : img_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
               pos_in = pos_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         pos_ff <= '0;
         img_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         pos_ff <= pos_in;
         img_ff <= img_in;
      end
   end

endmodule

### rtl/mipa_back.sv
`timescale 1ns / 1ps

module mipa_back #(
   parameter int MaxImages = 10,
   parameter int Depth = 65536,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int CntW = $clog2(MaxImages + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fifo_empty,
   output logic                    pop,
   input  logic [AddrW-1:0]        head_addr,
   input  mipa_pkg::job_flags_type head_flags,
   input  mipa_pkg::req_pixel_type head_pixel,
   input  logic [CntW-1:0]         count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mipa_pkg::rsp_pixel_type rsp_data
);

   import mipa_pkg::*;

   localparam int WordW = 3 * SUM_WIDTH;
   localparam int RcpShift = SUM_WIDTH + $clog2(MaxImages);
   localparam int RcpW = RcpShift + 1;
   localparam int ProdW = SUM_WIDTH + RcpW;

   back_state_type state_ff, state_in;

   logic [AddrW-1:0]     job_addr_ff, job_addr_in;
   job_flags_type        job_flags_ff, job_flags_in;
   req_pixel_type        job_pixel_ff, job_pixel_in;
   logic [SUM_WIDTH-1:0] red_sum_ff, red_sum_in;
   logic [SUM_WIDTH-1:0] green_sum_ff, green_sum_in;
   logic [SUM_WIDTH-1:0] blue_sum_ff, blue_sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_pixel_type        rsp_data_ff, rsp_data_in;

   logic                 rd_en, wr_en;
   logic [WordW-1:0]     rd_word, wr_word;
   logic [SUM_WIDTH-1:0] red_old, green_old, blue_old;

   logic [RcpW-1:0]      recip_tab [MaxImages + 1];
   logic [RcpW-1:0]      rcp;
   logic [ProdW-1:0]     red_prod, green_prod, blue_prod;
   logic                 out_free;

   // Reciprocals rounded up are exact for any sum that fits its width.
   assign recip_tab[0] = '0;
   for (genvar g = 1; g <= MaxImages; g++) begin : g_rcp
      localparam longint unsigned RcpVal = ((longint'(1) << RcpShift) + g - 1) / g;
      assign recip_tab[g] = RcpW'(RcpVal);
   end

   mipa_ram #(
      .Width(WordW),
      .Depth(Depth)
   ) u_sum_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(job_addr_ff),
      .wr_data(wr_word),
      .rd_en  (rd_en),
      .rd_addr(head_addr),
      .rd_data(rd_word)
   );

   assign red_old = job_flags_ff.first ? '0 : rd_word[2*SUM_WIDTH +: SUM_WIDTH];
   assign green_old = job_flags_ff.first ? '0 : rd_word[SUM_WIDTH +: SUM_WIDTH];
   assign blue_old = job_flags_ff.first ? '0 : rd_word[0 +: SUM_WIDTH];

   assign rcp = recip_tab[count];
   assign red_prod = ProdW'(red_sum_ff) * ProdW'(rcp);
   assign green_prod = ProdW'(green_sum_ff) * ProdW'(rcp);
   assign blue_prod = ProdW'(blue_sum_ff) * ProdW'(rcp);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      job_addr_in = job_addr_ff;
      job_flags_in = job_flags_ff;
      job_pixel_in = job_pixel_ff;
      red_sum_in = red_sum_ff;
      green_sum_in = green_sum_ff;
      blue_sum_in = blue_sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      pop = 1'b0;
      rd_en = 1'b0;
      wr_en = 1'b0;
      wr_word = {red_sum_in, green_sum_in, blue_sum_in};
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               pop = 1'b1;
               rd_en = 1'b1;
               job_addr_in = head_addr;
               job_flags_in = head_flags;
               job_pixel_in = head_pixel;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            red_sum_in = SUM_WIDTH'(job_pixel_ff.red_in) + red_old;
            green_sum_in = SUM_WIDTH'(job_pixel_ff.green_in) + green_old;
            blue_sum_in = SUM_WIDTH'(job_pixel_ff.blue_in) + blue_old;
            wr_en = 1'b1;
            wr_word = {red_sum_in, green_sum_in, blue_sum_in};
            state_in = job_flags_ff.last ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.red_avg = red_prod[RcpShift +: COMP_WIDTH];
               rsp_data_in.green_avg = green_prod[RcpShift +: COMP_WIDTH];
               rsp_data_in.blue_avg = blue_prod[RcpShift +: COMP_WIDTH];
               rsp_data_in.frame_done = job_flags_ff.frame_done;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_addr_ff <= job_addr_in;
      job_flags_ff <= job_flags_in;
      job_pixel_ff <= job_pixel_in;
      red_sum_ff <= red_sum_in;
      green_sum_ff <= green_sum_in;
      blue_sum_ff <= blue_sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### rtl/multi_image_pixel_average_unit.sv
`timescale 1ns / 1ps

// Frame averaging unit: pixels of image_count source images arrive image after image in
// raster order, and during the last image each pixel leaves as the truncated average of
// that position over all images, with frame_done on the final pixel of the composite.
// The front end takes one pixel per cycle while its two-entry queue has room; the back
// end does a read-modify-write of the sum memory per pixel, reading in ST_IDLE and
// writing in ST_SUM; last-image pixels then wait in ST_DIV, until the output is free,
// for the reciprocal multiply into the output register. It pops a pixel only when idle.
// Writing any register restarts the composite with a first image; the sum memory needs
// no clearing after reset because the first image writes every entry before it is read.
module multi_image_pixel_average_unit #(
   parameter int MaxWidth = mipa_pkg::MAX_WIDTH,
   parameter int MaxHeight = mipa_pkg::MAX_HEIGHT,
   parameter int MaxImages = mipa_pkg::MAX_IMAGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mipa_pkg::req_pixel_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mipa_pkg::rsp_pixel_type             rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mipa_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mipa_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [mipa_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   import mipa_pkg::*;

   localparam int Depth = MaxWidth * MaxHeight;
   localparam int ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
   localparam int RowW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(MaxImages + 1);
   localparam int FlagsW = $bits(job_flags_type);
   localparam int PixW = $bits(req_pixel_type);
   localparam int EntryW = AddrW + FlagsW + PixW;

   logic [COUNT_REG_WIDTH-1:0] image_count_ff, image_count_in;
   logic [DIM_REG_WIDTH-1:0]   frame_width_ff, frame_width_in;
   logic [DIM_REG_WIDTH-1:0]   frame_height_ff, frame_height_in;
   logic                       csr_write, restart;
   csr_reg_type                csr_reg;

   logic [31:0]     count_raw, width_raw, height_raw;
   logic [31:0]     count_eff, width_eff, height_eff;
   logic [CntW-1:0] count;
   logic [ColW-1:0] col_last;
   logic [RowW-1:0] row_last;

   logic            fifo_full, fifo_empty, push, pop;
   logic [AddrW-1:0] push_addr;
   job_flags_type   push_flags;
   req_pixel_type   push_pixel;
   logic [EntryW-1:0] push_entry, head_entry;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg = csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      image_count_in = image_count_ff;
      frame_width_in = frame_width_ff;
      frame_height_in = frame_height_ff;
      restart = 1'b0;
      csr_prdata = '0;
      case (csr_reg)
         REG_IMAGE_COUNT: begin
            csr_prdata = CSR_DATA_WIDTH'(image_count_ff);
            if (csr_write) begin
               image_count_in = csr_pwdata[COUNT_REG_WIDTH-1:0];
               restart = 1'b1;
            end
         end
         REG_FRAME_WIDTH: begin
            csr_prdata = CSR_DATA_WIDTH'(frame_width_ff);
            if (csr_write) begin
               frame_width_in = csr_pwdata[DIM_REG_WIDTH-1:0];
               restart = 1'b1;
            end
         end
         REG_FRAME_HEIGHT: begin
            csr_prdata = CSR_DATA_WIDTH'(frame_height_ff);
            if (csr_write) begin
               frame_height_in = csr_pwdata[DIM_REG_WIDTH-1:0];
               restart = 1'b1;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_count_ff <= IMAGE_COUNT_RESET;
         frame_width_ff <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         image_count_ff <= image_count_in;
         frame_width_ff <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // A zero register value counts as one and values above the maximum saturate.
   assign count_raw = 32'(image_count_ff);
   assign width_raw = 32'(frame_width_ff);
   assign height_raw = 32'(frame_height_ff);
   assign count_eff = (count_raw == '0) ? 32'd1 :
                      (count_raw > 32'(MaxImages)) ? 32'(MaxImages) : count_raw;
   assign width_eff = (width_raw == '0) ? 32'd1 :
                      (width_raw > 32'(MaxWidth)) ? 32'(MaxWidth) : width_raw;
   assign height_eff = (height_raw == '0) ? 32'd1 :
                       (height_raw > 32'(MaxHeight)) ? 32'(MaxHeight) : height_raw;
   assign count = count_eff[CntW-1:0];
   assign col_last = ColW'(width_eff - 32'd1);
   assign row_last = RowW'(height_eff - 32'd1);

   mipa_front #(
      .MaxWidth (MaxWidth),
      .MaxHeight(MaxHeight),
      .MaxImages(MaxImages)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .col_last  (col_last),
      .row_last  (row_last),
      .count     (count),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fifo_full (fifo_full),
      .push      (push),
      .push_addr (push_addr),
      .push_flags(push_flags),
      .push_pixel(push_pixel)
   );

   assign push_entry = {push_addr, push_flags, push_pixel};

   mipa_fifo #(
      .Width(EntryW),
      .Depth(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_entry),
      .pop      (pop),
      .head_data(head_entry),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   mipa_back #(
      .MaxImages(MaxImages),
      .Depth    (Depth)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .fifo_empty(fifo_empty),
      .pop       (pop),
      .head_addr (head_entry[FlagsW + PixW +: AddrW]),
      .head_flags(job_flags_type'(head_entry[PixW +: FlagsW])),
      .head_pixel(req_pixel_type'(head_entry[0 +: PixW])),
      .count     (count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### verif/tb_multi_image_pixel_average_unit.sv
`timescale 1ns / 1ps

module tb_multi_image_pixel_average_unit;
   import mipa_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 1050;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DIRECTED_ROWS = 23;

   typedef enum logic {
      ROW_PIXEL,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_reg_type   reg_sel;
      logic [31:0]   value;
      req_pixel_type px;
      logic [7:0]    reps;
      logic          typed;
      rsp_pixel_type avg;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_pixel_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_pixel_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   // Shadow of the block: settings, raster position and per-position sums.
   logic [COUNT_REG_WIDTH-1:0] model_count = IMAGE_COUNT_RESET;
   logic [DIM_REG_WIDTH-1:0] model_width = FRAME_WIDTH_RESET;
   logic [DIM_REG_WIDTH-1:0] model_height = FRAME_HEIGHT_RESET;
   int unsigned model_position = 0;
   int unsigned model_image = 0;
   logic [SUM_WIDTH-1:0] red_acc [MAX_WIDTH*MAX_HEIGHT];
   logic [SUM_WIDTH-1:0] green_acc [MAX_WIDTH*MAX_HEIGHT];
   logic [SUM_WIDTH-1:0] blue_acc [MAX_WIDTH*MAX_HEIGHT];

   rsp_pixel_type expected_avgs [$];
   rsp_pixel_type oldest_avg;
   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned random_target;
   int unsigned stall_hold = 0;
   bit quiet_phase = 1'b0;

   stim_row_type row;
   int unsigned shape;
   int unsigned composite_len;
   int unsigned phase_items;
   logic [31:0] phase_count;
   logic [31:0] phase_width;
   logic [31:0] phase_height;
   req_pixel_type random_px;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'hFF00FF, 8'd1, 1'b0, 25'd0},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'h00FF00, 8'd1, 1'b0, 25'd0},
      '{ROW_WRITE, REG_IMAGE_COUNT, 32'd1, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_WRITE, REG_FRAME_WIDTH, 32'd2, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd1, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'hFFFFFF, 8'd1, 1'b1,
        {8'hFF, 8'hFF, 8'hFF, 1'b0}},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'h000000, 8'd1, 1'b1,
        {8'h00, 8'h00, 8'h00, 1'b1}},
      '{ROW_WRITE, REG_IMAGE_COUNT, 32'd0, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'h807F01, 8'd1, 1'b1,
        {8'h80, 8'h7F, 8'h01, 1'b0}},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'h0180FE, 8'd1, 1'b1,
        {8'h01, 8'h80, 8'hFE, 1'b1}},
      '{ROW_WRITE, REG_IMAGE_COUNT, 32'd2, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_WRITE, REG_FRAME_WIDTH, 32'd0, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd0, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'hFFFFFF, 8'd2, 1'b1,
        {8'hFF, 8'hFF, 8'hFF, 1'b1}},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'h010203, 8'd1, 1'b0, 25'd0},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'h000001, 8'd1, 1'b0, 25'd0},
      '{ROW_WRITE, REG_IMAGE_COUNT, 32'd15, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'hFFFFFF, 8'd10, 1'b1,
        {8'hFF, 8'hFF, 8'hFF, 1'b1}},
      '{ROW_WRITE, REG_IMAGE_COUNT, 32'd1, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_WRITE, REG_FRAME_WIDTH, 32'd511, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd300, 24'h000000, 8'd0, 1'b0, 25'd0},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'hAA550F, 8'd1, 1'b1,
        {8'hAA, 8'h55, 8'h0F, 1'b0}},
      '{ROW_PIXEL, REG_IMAGE_COUNT, 32'd0, 24'h55AAF0, 8'd1, 1'b1,
        {8'h55, 8'hAA, 8'hF0, 1'b0}}
   };

   multi_image_pixel_average_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned clamp_setting(input int unsigned value,
                                                 input int unsigned limit);
      if (value < 1) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet_phase || roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Accumulates one pixel into the shadow sums; returns 1 when it yields an average.
   function automatic bit average_pixel(input req_pixel_type px, output rsp_pixel_type avg);
      int unsigned count;
      int unsigned total;
      int unsigned pos;
      bit first_image;
      bit last_image;
      count = clamp_setting(model_count, MAX_IMAGES);
      total = clamp_setting(model_width, MAX_WIDTH) * clamp_setting(model_height, MAX_HEIGHT);
      pos = (model_position >= total) ? 0 : model_position;
      if (model_image >= count) model_image = 0;
      first_image = (model_image == 0);
      last_image = (model_image == count - 1);
      red_acc[pos] = SUM_WIDTH'(px.red_in + (first_image ? 0 : red_acc[pos]));
      green_acc[pos] = SUM_WIDTH'(px.green_in + (first_image ? 0 : green_acc[pos]));
      blue_acc[pos] = SUM_WIDTH'(px.blue_in + (first_image ? 0 : blue_acc[pos]));
      avg.red_avg = COMP_WIDTH'(red_acc[pos] / count);
      avg.green_avg = COMP_WIDTH'(green_acc[pos] / count);
      avg.blue_avg = COMP_WIDTH'(blue_acc[pos] / count);
      avg.frame_done = (pos == total - 1);
      pos++;
      if (pos >= total) begin
         pos = 0;
         model_image++;
         if (model_image >= count) model_image = 0;
      end
      model_position = pos;
      return last_image;
   endfunction

   function automatic void compare_field(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   task automatic send_pixel(input req_pixel_type px, input bit typed,
                             input rsp_pixel_type typed_avg);
      rsp_pixel_type avg;
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= px;
      req_valid <= 1'b1;
      if (average_pixel(px, avg)) expected_avgs.push_back(typed ? typed_avg : avg);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_avgs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apb_access(input csr_reg_type reg_sel, input logic is_write,
                             input logic [CSR_DATA_WIDTH-1:0] wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= CSR_ADDR_WIDTH'({reg_sel, 2'b00});
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_register(input csr_reg_type reg_sel, input logic [31:0] value);
      logic [CSR_DATA_WIDTH-1:0] stored;
      logic [CSR_DATA_WIDTH-1:0] readback;
      stored = (reg_sel == REG_IMAGE_COUNT) ? CSR_DATA_WIDTH'(value[COUNT_REG_WIDTH-1:0])
                                            : CSR_DATA_WIDTH'(value[DIM_REG_WIDTH-1:0]);
      wait_until_idle();
      apb_access(reg_sel, 1'b1, value, readback);
      apb_access(reg_sel, 1'b0, '0, readback);
      compare_field(reg_sel.name(), stored, readback);
      case (reg_sel)
         REG_IMAGE_COUNT: model_count = value[COUNT_REG_WIDTH-1:0];
         REG_FRAME_WIDTH: model_width = value[DIM_REG_WIDTH-1:0];
         REG_FRAME_HEIGHT: model_height = value[DIM_REG_WIDTH-1:0];
         default: ;
      endcase
      model_position = 0;
      model_image = 0;
   endtask

   always @(negedge clock) begin
      if (quiet_phase) begin
         rsp_stall <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_avgs.size() == 0) begin
            $error("result item with no average pending: %h", rsp_data);
            errors++;
         end else begin
            oldest_avg = expected_avgs.pop_front();
            compare_field("red_avg", oldest_avg.red_avg, rsp_data.red_avg);
            compare_field("green_avg", oldest_avg.green_avg, rsp_data.green_avg);
            compare_field("blue_avg", oldest_avg.blue_avg, rsp_data.blue_avg);
            compare_field("frame_done", oldest_avg.frame_done, rsp_data.frame_done);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            write_register(row.reg_sel, row.value);
         end else begin
            repeat (row.reps) send_pixel(row.px, row.typed, row.avg);
         end
      end

      // Mostly whole composites with random content; some end in a partial composite
      // that the next register write cuts off.
      random_target = pixels_sent + RANDOM_ITEMS;
      while (pixels_sent < random_target) begin
         shape = $urandom_range(0, 9);
         phase_count = $urandom_range(0, 15);
         phase_width = $urandom_range(0, 6);
         phase_height = $urandom_range(0, 6);
         if (shape == 0) begin
            phase_width = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(257, 511);
            phase_height = $urandom_range(0, 1);
            phase_count = $urandom_range(0, 2);
         end else if (shape == 1) begin
            phase_height = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(257, 511);
            phase_width = $urandom_range(0, 1);
            phase_count = $urandom_range(0, 2);
         end
         write_register(REG_IMAGE_COUNT, phase_count);
         write_register(REG_FRAME_WIDTH, phase_width);
         write_register(REG_FRAME_HEIGHT, phase_height);
         quiet_phase = ($urandom_range(0, 4) == 0);
         composite_len = clamp_setting(phase_count, MAX_IMAGES)
                       * clamp_setting(phase_width, MAX_WIDTH)
                       * clamp_setting(phase_height, MAX_HEIGHT);
         phase_items = (shape < 2) ? composite_len : composite_len * $urandom_range(1, 2);
         if (shape >= 2 && $urandom_range(0, 2) == 0)
            phase_items += $urandom_range(1, composite_len);
         if (phase_items > random_target - pixels_sent)
            phase_items = random_target - pixels_sent;
         repeat (phase_items) begin
            random_px = ($urandom_range(0, 7) == 0) ? '1 : req_pixel_type'(24'($urandom));
            send_pixel(random_px, 1'b0, '0);
         end
      end

      wait_until_idle();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
